### hdl/pws_pkg.sv
// Shared types, constants and helper functions for the Porter word stemmer.
// Used by every module of the block; depends on nothing else.
package pws_pkg;

    localparam int MAX_LEN  = 32;
    localparam int LEN_W    = $clog2(MAX_LEN + 1);
    localparam int IDX_W    = $clog2(MAX_LEN);
    localparam int STEM_W   = 6;
    localparam int WIN      = 7;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int RULE_CNT = 47;

    localparam logic [5:0] R2_FIRST = 6'd0;
    localparam logic [5:0] R2_LAST  = 6'd20;
    localparam logic [5:0] R3_FIRST = 6'd21;
    localparam logic [5:0] R3_LAST  = 6'd27;
    localparam logic [5:0] R4_FIRST = 6'd28;
    localparam logic [5:0] R4_LAST  = 6'd46;

    localparam logic [7:0] CH_A = "a";
    localparam logic [7:0] CH_E = "e";
    localparam logic [7:0] CH_I = "i";
    localparam logic [7:0] CH_O = "o";
    localparam logic [7:0] CH_U = "u";
    localparam logic [7:0] CH_Y = "y";
    localparam logic [7:0] CH_S = "s";
    localparam logic [7:0] CH_T = "t";
    localparam logic [7:0] CH_L = "l";
    localparam logic [7:0] CH_Z = "z";
    localparam logic [7:0] CH_W = "w";
    localparam logic [7:0] CH_X = "x";

    // one queued character between front and back
    typedef struct packed {
        logic [7:0] ch;
        logic       wr;    // goes into the letter store
        logic       last;  // ends the word
        logic       ovf;   // word lost characters so far
    } t_entry;

    // w[0] is the final letter of the word, w[1] the one before, ...
    typedef logic [WIN-1:0][7:0] t_win;

    // suffix right-justified (last char in the low byte), replacement likewise
    typedef struct packed {
        logic [55:0] sfx;
        logic [2:0]  slen;
        logic [31:0] rep;
        logic [2:0]  rlen;
        logic        ion;  // needs s or t in front
    } t_rule;

    localparam t_rule RULES [RULE_CNT] = '{
        '{56'("ational"), 3'd7, 32'("ate"),  3'd3, 1'b0},
        '{56'("tional"),  3'd6, 32'("tion"), 3'd4, 1'b0},
        '{56'("enci"),    3'd4, 32'("ence"), 3'd4, 1'b0},
        '{56'("anci"),    3'd4, 32'("ance"), 3'd4, 1'b0},
        '{56'("izer"),    3'd4, 32'("ize"),  3'd3, 1'b0},
        '{56'("bli"),     3'd3, 32'("ble"),  3'd3, 1'b0},
        '{56'("alli"),    3'd4, 32'("al"),   3'd2, 1'b0},
        '{56'("entli"),   3'd5, 32'("ent"),  3'd3, 1'b0},
        '{56'("eli"),     3'd3, 32'("e"),    3'd1, 1'b0},
        '{56'("ousli"),   3'd5, 32'("ous"),  3'd3, 1'b0},
        '{56'("ization"), 3'd7, 32'("ize"),  3'd3, 1'b0},
        '{56'("ation"),   3'd5, 32'("ate"),  3'd3, 1'b0},
        '{56'("ator"),    3'd4, 32'("ate"),  3'd3, 1'b0},
        '{56'("alism"),   3'd5, 32'("al"),   3'd2, 1'b0},
        '{56'("iveness"), 3'd7, 32'("ive"),  3'd3, 1'b0},
        '{56'("fulness"), 3'd7, 32'("ful"),  3'd3, 1'b0},
        '{56'("ousness"), 3'd7, 32'("ous"),  3'd3, 1'b0},
        '{56'("aliti"),   3'd5, 32'("al"),   3'd2, 1'b0},
        '{56'("iviti"),   3'd5, 32'("ive"),  3'd3, 1'b0},
        '{56'("biliti"),  3'd6, 32'("ble"),  3'd3, 1'b0},
        '{56'("logi"),    3'd4, 32'("log"),  3'd3, 1'b0},
        '{56'("icate"),   3'd5, 32'("ic"),   3'd2, 1'b0},
        '{56'("ative"),   3'd5, 32'h0,       3'd0, 1'b0},
        '{56'("alize"),   3'd5, 32'("al"),   3'd2, 1'b0},
        '{56'("iciti"),   3'd5, 32'("ic"),   3'd2, 1'b0},
        '{56'("ical"),    3'd4, 32'("ic"),   3'd2, 1'b0},
        '{56'("ful"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ness"),    3'd4, 32'h0,       3'd0, 1'b0},
        '{56'("al"),      3'd2, 32'h0,       3'd0, 1'b0},
        '{56'("ance"),    3'd4, 32'h0,       3'd0, 1'b0},
        '{56'("ence"),    3'd4, 32'h0,       3'd0, 1'b0},
        '{56'("er"),      3'd2, 32'h0,       3'd0, 1'b0},
        '{56'("ic"),      3'd2, 32'h0,       3'd0, 1'b0},
        '{56'("able"),    3'd4, 32'h0,       3'd0, 1'b0},
        '{56'("ible"),    3'd4, 32'h0,       3'd0, 1'b0},
        '{56'("ant"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ement"),   3'd5, 32'h0,       3'd0, 1'b0},
        '{56'("ment"),    3'd4, 32'h0,       3'd0, 1'b0},
        '{56'("ent"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ion"),     3'd3, 32'h0,       3'd0, 1'b1},
        '{56'("ou"),      3'd2, 32'h0,       3'd0, 1'b0},
        '{56'("ism"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ate"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("iti"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ous"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ive"),     3'd3, 32'h0,       3'd0, 1'b0},
        '{56'("ize"),     3'd3, 32'h0,       3'd0, 1'b0}
    };

    function automatic logic is_aeiou(input logic [7:0] c);
        return c == CH_A || c == CH_E || c == CH_I || c == CH_O || c == CH_U;
    endfunction

    // window slots past the word start hold 0, which never matches a letter
    function automatic logic ends_with(input t_win w, input logic [55:0] s,
                                       input logic [2:0] n);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < WIN; k++) begin
            if (3'(k) < n && w[k] != s[8*k +: 8]) ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

### hdl/pws_queue.sv
// Short character queue between the front classifier and the stemming back end.
// Depends on pws_pkg for the entry type and depth.
module pws_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pws_pkg::t_entry i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output pws_pkg::t_entry o_data
);
    import pws_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wp, r_rp;
    logic [QPTR_W:0]     r_cnt;
    logic [QPTR_W-1:0]   n_wp, n_rp;
    logic [QPTR_W:0]     n_cnt;
    logic                do_push, do_pop;

    assign o_full  = r_cnt == (QPTR_W+1)'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = do_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt;
        if (do_push && !do_pop) n_cnt = r_cnt + 1'b1;
        if (!do_push && do_pop) n_cnt = r_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

### hdl/pws_front.sv
// Front end: takes input characters, drops zeros, counts the word length
// and flags overflow, and queues the characters that matter. Uses pws_pkg.
module pws_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_char,
    input  logic            i_last,
    input  logic            i_q_full,
    output logic            o_q_push,
    output pws_pkg::t_entry o_q_data
);
    import pws_pkg::*;

    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic             accept, store, ovf_now;

    assign accept  = i_push && !i_q_full;
    assign store   = accept && i_char != 8'h00 && r_cnt < LEN_W'(MAX_LEN);
    assign ovf_now = r_ovf || (accept && i_char != 8'h00 && r_cnt >= LEN_W'(MAX_LEN));

    assign o_q_push = accept && (store || i_last);
    assign o_q_data = '{ch: i_char, wr: store, last: i_last, ovf: ovf_now};

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        if (accept) begin
            if (i_last) begin
                n_cnt = '0;
                n_ovf = 1'b0;
            end else begin
                n_cnt = r_cnt + LEN_W'(store);
                n_ovf = ovf_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
    end

endmodule

### hdl/pws_back.sv
// Back end: letter store, stemming sequencer and result register.
// One letter-store read per cycle; depends on pws_pkg for rules and helpers.
module pws_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  pws_pkg::t_entry            i_q_data,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic [7:0]                 o_char,
    output logic                       o_last,
    output logic [pws_pkg::STEM_W-1:0] o_stem_length,
    output logic                       o_truncated
);
    import pws_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_START  = 5'd1;
    localparam logic [4:0] S_LOAD   = 5'd2;
    localparam logic [4:0] S_SCAN   = 5'd3;
    localparam logic [4:0] S_WRITE  = 5'd4;
    localparam logic [4:0] S_1A     = 5'd5;
    localparam logic [4:0] S_1B     = 5'd6;
    localparam logic [4:0] S_1B_EED = 5'd7;
    localparam logic [4:0] S_1B_ED  = 5'd8;
    localparam logic [4:0] S_1B_ING = 5'd9;
    localparam logic [4:0] S_1B2    = 5'd10;
    localparam logic [4:0] S_1B3    = 5'd11;
    localparam logic [4:0] S_1C     = 5'd12;
    localparam logic [4:0] S_1C2    = 5'd13;
    localparam logic [4:0] S_NEXT   = 5'd14;
    localparam logic [4:0] S_RULE   = 5'd15;
    localparam logic [4:0] S_RULE_M = 5'd16;
    localparam logic [4:0] S_5A     = 5'd17;
    localparam logic [4:0] S_5A2    = 5'd18;
    localparam logic [4:0] S_5B     = 5'd19;
    localparam logic [4:0] S_5B2    = 5'd20;
    localparam logic [4:0] S_EMIT   = 5'd21;

    localparam logic [1:0] P1 = 2'd0;
    localparam logic [1:0] P2 = 2'd1;
    localparam logic [1:0] P3 = 2'd2;
    localparam logic [1:0] P4 = 2'd3;

    logic [7:0]        r_mem [MAX_LEN];
    logic [4:0]        r_st, n_st, r_ret, n_ret;
    logic [LEN_W-1:0]  r_wl, n_wl, r_i, n_i, r_n, n_n, r_m, n_m, r_base, n_base;
    logic              r_ovf, n_ovf, r_anyv, n_anyv, r_prev, n_prev;
    logic [2:0]        r_v3, n_v3, r_k, n_k, r_rlen, n_rlen;
    t_win              r_w, n_w;
    logic [31:0]       r_rep, n_rep;
    logic [5:0]        r_rule, n_rule, r_rend, n_rend;
    logic              r_cond, n_cond;
    logic [1:0]        r_step, n_step;
    logic              r_ovalid, n_ovalid, r_olast, n_olast, r_otr, n_otr;
    logic [7:0]        r_och, n_och;
    logic [STEM_W-1:0] r_olen, n_olen;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa, rd_idx;
    logic [7:0]        mem_wd, rd_ch;
    logic [LEN_W-1:0]  ld_pos, wr_pos, tail_pos;
    logic [1:0]        rep_sel;
    logic              v, ld_out, rule_hit;
    t_rule             rule;

    function automatic logic cvc(input logic [7:0] c, input logic [2:0] vv,
                                 input logic [LEN_W-1:0] n);
        return n >= LEN_W'(3) && c != CH_W && c != CH_X && c != CH_Y
            && !vv[0] && vv[1] && !vv[2];
    endfunction

    assign ld_pos  = r_wl - LEN_W'(r_k) - LEN_W'(1);
    assign wr_pos  = r_base + r_i;
    assign tail_pos = r_wl - LEN_W'(1);
    assign rep_sel = 2'(r_rlen - 3'd1 - r_i[2:0]);
    assign rule    = RULES[r_rule];
    assign rule_hit = ends_with(r_w, rule.sfx, rule.slen)
                   && (!rule.ion || r_w[3] == CH_S || r_w[3] == CH_T);

    always_comb begin
        unique case (r_st)
            S_LOAD:  rd_idx = ld_pos[IDX_W-1:0];
            default: rd_idx = r_i[IDX_W-1:0];
        endcase
    end
    assign rd_ch = r_mem[rd_idx];
    assign v     = is_aeiou(rd_ch) || (rd_ch == CH_Y && r_i != '0 && !r_prev);
    assign ld_out = !r_ovalid || i_pop;

    always_comb begin
        n_st = r_st;  n_ret = r_ret;  n_wl = r_wl;  n_i = r_i;  n_n = r_n;
        n_m = r_m;  n_base = r_base;  n_ovf = r_ovf;  n_anyv = r_anyv;
        n_prev = r_prev;  n_v3 = r_v3;  n_k = r_k;  n_rlen = r_rlen;
        n_w = r_w;  n_rep = r_rep;  n_rule = r_rule;  n_rend = r_rend;
        n_cond = r_cond;  n_step = r_step;
        n_ovalid = r_ovalid && !i_pop;
        n_och = r_och;  n_olast = r_olast;  n_otr = r_otr;  n_olen = r_olen;
        mem_we = 1'b0;  mem_wa = '0;  mem_wd = '0;  o_q_pop = 1'b0;

        unique case (r_st)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_data.wr) begin
                        mem_we = 1'b1;
                        mem_wa = r_wl[IDX_W-1:0];
                        mem_wd = i_q_data.ch;
                        n_wl   = r_wl + LEN_W'(1);
                    end
                    if (i_q_data.last) begin
                        n_ovf = i_q_data.ovf;
                        n_st  = S_START;
                    end
                end
            end
            S_START: begin
                n_step = P1;
                if (r_wl <= LEN_W'(2)) begin
                    n_i  = '0;
                    n_st = S_EMIT;
                end else begin
                    n_k = '0;  n_ret = S_1A;  n_st = S_LOAD;
                end
            end
            S_LOAD: begin
                n_w[r_k] = (LEN_W'(r_k) < r_wl) ? rd_ch : 8'h00;
                if (r_k == 3'(WIN - 1)) n_st = r_ret;
                else                    n_k  = r_k + 3'd1;
            end
            S_SCAN: begin
                if (r_i == r_n) begin
                    n_st = r_ret;
                end else begin
                    n_prev = v;
                    n_anyv = r_anyv || v;
                    n_v3   = {r_v3[1:0], v};
                    if (r_i != '0 && r_prev && !v) n_m = r_m + LEN_W'(1);
                    n_i = r_i + LEN_W'(1);
                end
            end
            S_WRITE: begin
                if (r_i == LEN_W'(r_rlen)) begin
                    n_wl = r_base + LEN_W'(r_rlen);
                    n_k  = '0;
                    n_st = S_LOAD;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = wr_pos[IDX_W-1:0];
                    mem_wd = r_rep[8*rep_sel +: 8];
                    n_i    = r_i + LEN_W'(1);
                end
            end
            S_1A: begin
                n_st = S_1B;
                if (r_w[0] == CH_S) begin
                    n_k = '0;  n_ret = S_1B;
                    if (ends_with(r_w, 56'("sses"), 3'd4)
                        || ends_with(r_w, 56'("ies"), 3'd3)) begin
                        n_wl = r_wl - LEN_W'(2);  n_st = S_LOAD;
                    end else if (!ends_with(r_w, 56'("ss"), 3'd2)) begin
                        n_wl = r_wl - LEN_W'(1);  n_st = S_LOAD;
                    end
                end
            end
            S_1B: begin
                n_i = '0;  n_m = '0;  n_anyv = 1'b0;  n_prev = 1'b0;  n_v3 = '0;
                if (ends_with(r_w, 56'("eed"), 3'd3)) begin
                    n_n = r_wl - LEN_W'(3);  n_ret = S_1B_EED;  n_st = S_SCAN;
                end else if (ends_with(r_w, 56'("ed"), 3'd2)) begin
                    n_n = r_wl - LEN_W'(2);  n_ret = S_1B_ED;  n_st = S_SCAN;
                end else if (ends_with(r_w, 56'("ing"), 3'd3)) begin
                    n_n = r_wl - LEN_W'(3);  n_ret = S_1B_ING;  n_st = S_SCAN;
                end else begin
                    n_st = S_1C;
                end
            end
            S_1B_EED: begin
                n_st = S_1C;
                if (r_m != '0) begin
                    n_wl = r_wl - LEN_W'(1);  n_k = '0;  n_ret = S_1C;  n_st = S_LOAD;
                end
            end
            S_1B_ED: begin
                n_st = S_1C;
                if (r_anyv) begin
                    n_wl = r_wl - LEN_W'(2);  n_k = '0;  n_ret = S_1B2;  n_st = S_LOAD;
                end
            end
            S_1B_ING: begin
                n_st = S_1C;
                if (r_anyv) begin
                    n_wl = r_wl - LEN_W'(3);  n_k = '0;  n_ret = S_1B2;  n_st = S_LOAD;
                end
            end
            S_1B2: begin
                n_st = S_1C;
                n_base = r_wl - LEN_W'(2);  n_rlen = 3'd3;  n_i = '0;  n_ret = S_1C;
                if (r_wl >= LEN_W'(2)) begin
                    if (ends_with(r_w, 56'("at"), 3'd2)) begin
                        n_rep = 32'("ate");  n_st = S_WRITE;
                    end else if (ends_with(r_w, 56'("bl"), 3'd2)) begin
                        n_rep = 32'("ble");  n_st = S_WRITE;
                    end else if (ends_with(r_w, 56'("iz"), 3'd2)) begin
                        n_rep = 32'("ize");  n_st = S_WRITE;
                    end else begin
                        n_m = '0;  n_anyv = 1'b0;  n_prev = 1'b0;  n_v3 = '0;
                        n_n = r_wl;  n_ret = S_1B3;  n_st = S_SCAN;
                    end
                end
            end
            S_1B3: begin
                n_st = S_1C;
                n_k = '0;  n_ret = S_1C;
                if (r_w[0] == r_w[1] && !r_v3[0]) begin
                    if (r_w[0] != CH_L && r_w[0] != CH_S && r_w[0] != CH_Z) begin
                        n_wl = r_wl - LEN_W'(1);  n_st = S_LOAD;
                    end
                end else if (r_m == LEN_W'(1) && cvc(r_w[0], r_v3, r_wl)) begin
                    mem_we = 1'b1;
                    mem_wa = r_wl[IDX_W-1:0];
                    mem_wd = CH_E;
                    n_wl   = r_wl + LEN_W'(1);
                    n_st   = S_LOAD;
                end
            end
            S_1C: begin
                n_st = S_NEXT;
                if (r_wl > LEN_W'(1) && r_w[0] == CH_Y) begin
                    n_i = '0;  n_m = '0;  n_anyv = 1'b0;  n_prev = 1'b0;  n_v3 = '0;
                    n_n = r_wl - LEN_W'(1);  n_ret = S_1C2;  n_st = S_SCAN;
                end
            end
            S_1C2: begin
                n_st = S_NEXT;
                if (r_anyv) begin
                    mem_we = 1'b1;
                    mem_wa = tail_pos[IDX_W-1:0];
                    mem_wd = CH_I;
                    n_w[0] = CH_I;
                end
            end
            S_NEXT: begin
                unique case (r_step)
                    P1: begin
                        n_rule = R2_FIRST;  n_rend = R2_LAST;  n_cond = 1'b0;
                        n_step = P2;  n_st = S_RULE;
                    end
                    P2: begin
                        n_rule = R3_FIRST;  n_rend = R3_LAST;  n_cond = 1'b0;
                        n_step = P3;  n_st = S_RULE;
                    end
                    P3: begin
                        n_rule = R4_FIRST;  n_rend = R4_LAST;  n_cond = 1'b1;
                        n_step = P4;  n_st = S_RULE;
                    end
                    default: n_st = S_5A;
                endcase
            end
            S_RULE: begin
                if (rule_hit) begin
                    n_base = r_wl - LEN_W'(rule.slen);
                    n_n    = r_wl - LEN_W'(rule.slen);
                    n_i = '0;  n_m = '0;  n_anyv = 1'b0;  n_prev = 1'b0;  n_v3 = '0;
                    n_ret = S_RULE_M;  n_st = S_SCAN;
                end else if (r_rule == r_rend) begin
                    n_st = S_NEXT;
                end else begin
                    n_rule = r_rule + 6'd1;
                end
            end
            S_RULE_M: begin
                n_st = S_NEXT;
                if (r_m > LEN_W'(r_cond)) begin
                    n_rep = rule.rep;  n_rlen = rule.rlen;  n_i = '0;
                    n_ret = S_NEXT;    n_st = S_WRITE;
                end
            end
            S_5A: begin
                n_st = S_5B;
                if (r_wl > LEN_W'(2) && r_w[0] == CH_E) begin
                    n_i = '0;  n_m = '0;  n_anyv = 1'b0;  n_prev = 1'b0;  n_v3 = '0;
                    n_n = r_wl - LEN_W'(1);  n_ret = S_5A2;  n_st = S_SCAN;
                end
            end
            S_5A2: begin
                n_st = S_5B;
                if (r_m > LEN_W'(1)
                    || (r_m == LEN_W'(1) && !cvc(r_w[1], r_v3, r_wl - LEN_W'(1)))) begin
                    n_wl = r_wl - LEN_W'(1);  n_k = '0;  n_ret = S_5B;  n_st = S_LOAD;
                end
            end
            S_5B: begin
                n_i = '0;
                n_st = S_EMIT;
                if (r_wl >= LEN_W'(5) && r_w[0] == CH_L && r_w[1] == CH_L) begin
                    n_m = '0;  n_anyv = 1'b0;  n_prev = 1'b0;  n_v3 = '0;
                    n_n = r_wl;  n_ret = S_5B2;  n_st = S_SCAN;
                end
            end
            S_5B2: begin
                if (r_m > LEN_W'(1)) n_wl = r_wl - LEN_W'(1);
                n_i  = '0;
                n_st = S_EMIT;
            end
            S_EMIT: begin
                if (ld_out) begin
                    n_ovalid = 1'b1;
                    n_otr    = r_ovf;
                    n_olen   = STEM_W'(r_wl);
                    if (r_wl == '0) begin
                        n_och   = 8'h00;
                        n_olast = 1'b1;
                    end else begin
                        n_och   = rd_ch;
                        n_olast = r_i == r_wl - LEN_W'(1);
                        n_i     = r_i + LEN_W'(1);
                    end
                    if (r_wl == '0 || r_i == r_wl - LEN_W'(1)) begin
                        n_wl  = '0;
                        n_ovf = 1'b0;
                        n_st  = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_wl     <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_wl     <= n_wl;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret  <= n_ret;   r_i    <= n_i;     r_n    <= n_n;     r_m    <= n_m;
        r_base <= n_base;  r_anyv <= n_anyv;  r_prev <= n_prev;  r_v3   <= n_v3;
        r_k    <= n_k;     r_rlen <= n_rlen;  r_w    <= n_w;     r_rep  <= n_rep;
        r_rule <= n_rule;  r_rend <= n_rend;  r_cond <= n_cond;  r_step <= n_step;
        r_och  <= n_och;   r_olast <= n_olast; r_otr <= n_otr;   r_olen <= n_olen;
        if (mem_we) r_mem[mem_wa] <= mem_wd;
    end

    assign o_empty       = !r_ovalid;
    assign o_char        = r_och;
    assign o_last        = r_olast;
    assign o_stem_length = r_olen;
    assign o_truncated   = r_otr;

endmodule

### hdl/porter_word_stemmer_core.sv
// Top level of the Porter word stemmer: front classifier, character queue, back end.
// Depends on pws_pkg, pws_front, pws_queue and pws_back.
//
//  channel   handshake            fields
//  input     push / full          i_in_char, i_in_last
//  result    pop / empty          o_out_char, o_out_last, o_stem_length, o_truncated
//
// Characters are taken one per cycle, while the queue is not full, into a
// 4-entry queue; the back end moves them into the letter store at one per
// cycle while idle. A word of two letters or fewer goes straight out; a
// longer one is stemmed rule by rule, with tail reloads and length-long scans.
// The stem leaves through an output register, one character per cycle when popped.
// Synchronous active-low reset clears control state only; no clearing pass.
module porter_word_stemmer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [7:0]                 i_in_char,
    input  logic                       i_in_last,
    output logic                       empty,
    input  logic                       pop,
    output logic [7:0]                 o_out_char,
    output logic                       o_out_last,
    output logic [pws_pkg::STEM_W-1:0] o_stem_length,
    output logic                       o_truncated
);
    import pws_pkg::*;

    logic   q_push, q_full, q_pop, q_empty;
    t_entry q_in, q_out;

    assign full = q_full;

    pws_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_char   (i_in_char),
        .i_last   (i_in_last),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in)
    );

    pws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    pws_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_out),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_char        (o_out_char),
        .o_last        (o_out_last),
        .o_stem_length (o_stem_length),
        .o_truncated   (o_truncated)
    );

endmodule

### hdl/pws_checker.sv
// Port-level checks for the Porter word stemmer, bound to the top level.
// Depends on pws_pkg and porter_word_stemmer_core.
module pws_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       push,
    input logic                       full,
    input logic [7:0]                 i_in_char,
    input logic                       i_in_last,
    input logic                       empty,
    input logic                       pop,
    input logic [7:0]                 o_out_char,
    input logic                       o_out_last,
    input logic [pws_pkg::STEM_W-1:0] o_stem_length,
    input logic                       o_truncated
);
    import pws_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_rst_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_char) && $stable(o_out_last))
        else $error("waiting word changed");

    a_empty_stem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_stem_length == '0 |-> o_out_last && o_out_char == 8'h00)
        else $error("empty stem not a single zero word");

    a_len_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_out_last |-> o_stem_length > STEM_W'(1))
        else $error("non-final word of a one-letter stem");

endmodule

bind porter_word_stemmer_core pws_checker u_pws_checker (.*);
